// ----- hw/rtl/gww_pkg.sv -----
// gww_pkg: shared constants and the delimiter test for the greedy word wrap block
// no dependencies; used by the top level and the checker
`default_nettype none

package gww_pkg;

    localparam int MAX_WORD = 63;
    localparam int BYTE_W   = 8;
    localparam int LINE_W   = 7;

    localparam logic [LINE_W-1:0] RESET_WIDTH = 7'd20;

    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_PERIOD  = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_BANG    = 8'h21;
    localparam logic [BYTE_W-1:0] CH_QUERY   = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_LPAREN  = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN  = 8'h29;

    function automatic logic is_delim(input logic [BYTE_W-1:0] ch);
        return (ch == CH_SPACE)  || (ch == CH_COMMA)  || (ch == CH_PERIOD) ||
               (ch == CH_BANG)   || (ch == CH_QUERY)  || (ch == CH_LPAREN) ||
               (ch == CH_RPAREN) || (ch == CH_NEWLINE);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gww_ram.sv -----
// gww_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module gww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/greedy_word_wrap_top.sv -----
// greedy word wrap: a byte that does not end a word is only stored in the ram; when a
// word is flushed, a newline state comes first if a newline is inserted, and the output
// can stall it, as each stored byte needs a ram read state and an output load state.
// the input is not ready while a word is flushed; the next input beat is taken
// in the cycle after the last byte is loaded into the output register.
// synchronous active-low reset clears counts and output valid, width goes to 20.
// depends on gww_pkg and gww_ram
`default_nettype none

module greedy_word_wrap_top #(
    parameter int MAX_WORD = gww_pkg::MAX_WORD
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // config write
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [gww_pkg::LINE_W-1:0]  i_cfg_data,   // line_width
    // input stream
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [gww_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] in_byte
    input  wire logic                        s_axis_tlast,  // end_of_text
    // output stream
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [gww_pkg::BYTE_W-1:0]  m_axis_tdata,  // [7:0] out_byte
    output logic                             m_axis_tlast   // last_of_run
);

    import gww_pkg::*;

    localparam int AW    = $clog2(MAX_WORD);
    localparam int LEN_W = $clog2(MAX_WORD + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_NL   = 4'b0010,
        S_RD   = 4'b0100,
        S_LD   = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [LINE_W-1:0]   r_width;
    logic [LINE_W-1:0]   r_line, n_line;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [LEN_W-1:0]    r_flen, n_flen;
    logic [AW-1:0]       r_idx, n_idx;
    logic                r_ov, n_ov;
    logic [BYTE_W-1:0]   r_obyte, n_obyte;
    logic                r_olast, n_olast;

    logic                in_acc;
    logic                slot_free;
    logic [LEN_W-1:0]    len_new;
    logic                flush;
    logic [LINE_W:0]     sum;
    logic                need_nl;
    logic [BYTE_W-1:0]   rdata;
    logic                at_end;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign slot_free = !r_ov || m_axis_tready;
    assign len_new   = r_len + LEN_W'(1);
    assign flush     = is_delim(s_axis_tdata) || s_axis_tlast ||
                       (len_new == LEN_W'(MAX_WORD));
    assign sum       = {1'b0, r_line} + (LINE_W + 1)'(len_new);
    assign need_nl   = sum > {1'b0, r_width};
    assign at_end    = (LEN_W'(r_idx) + LEN_W'(1)) == r_flen;

    gww_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_WORD),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        n_line  = r_line;
        n_len   = r_len;
        n_flen  = r_flen;
        n_idx   = r_idx;
        n_ov    = r_ov && !m_axis_tready;
        n_obyte = r_obyte;
        n_olast = r_olast;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (flush) begin
                        n_len  = '0;
                        n_flen = len_new;
                        n_idx  = '0;
                        if (s_axis_tdata == CH_NEWLINE) begin
                            n_line = '0;
                        end else if (need_nl) begin
                            n_line = LINE_W'(len_new);
                        end else begin
                            n_line = sum[LINE_W-1:0];
                        end
                        n_state = need_nl ? S_NL : S_RD;
                    end else begin
                        n_len = len_new;
                    end
                end
            end
            S_NL: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_obyte = CH_NEWLINE;
                    n_olast = 1'b0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_obyte = rdata;
                    n_olast = at_end;
                    if (at_end) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_width <= RESET_WIDTH;
            r_line  <= '0;
            r_len   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_line  <= n_line;
            r_len   <= n_len;
            r_ov    <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                r_width <= i_cfg_data;
            end
        end
        r_flen  <= n_flen;
        r_idx   <= n_idx;
        r_obyte <= n_obyte;
        r_olast <= n_olast;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_obyte;
    assign m_axis_tlast  = r_olast;

endmodule

`default_nettype wire

// ----- hw/rtl/gww_checker.sv -----
// gww_checker: port-level checks for greedy_word_wrap_top, bound to the top level
// depends on gww_pkg
`default_nettype none

module gww_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       s_axis_tvalid,
    input wire logic                       s_axis_tready,
    input wire logic [gww_pkg::BYTE_W-1:0] s_axis_tdata,
    input wire logic                       m_axis_tvalid,
    input wire logic                       m_axis_tready,
    input wire logic [gww_pkg::BYTE_W-1:0] m_axis_tdata,
    input wire logic                       m_axis_tlast
);

    import gww_pkg::*;

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // a delimiter always starts a flush, so the input closes
    a_delim_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && is_delim(s_axis_tdata) |=> !s_axis_tready)
        else $error("input ready right after a delimiter");

    // a beat inside a run is only produced while a flush is under way
    a_mid_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("mid-run output beat while input ready");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind greedy_word_wrap_top gww_checker u_gww_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
